### rtl/core/spgc_pkg.sv
// Shared types and constants for the stereo pan gain chaser.
// Used by the multiplier, divider, top level and bench; depends on nothing.
package spgc_pkg;

  localparam int GAIN_W     = 24;
  localparam int SPEED_W    = 32;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int QUOT_W     = 24;
  localparam int NUM_W      = SPEED_W + QUOT_W;
  localparam int DIV_CNT_W  = $clog2(QUOT_W + 1);
  localparam int GAIN_FRAC  = 22;
  localparam int SPEED_FRAC = 20;
  localparam int DECAY_SHIFT = 30;
  localparam int ADDR_W     = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd4194304;
  localparam logic [SPEED_W-1:0] SPEED_ONE   = 32'd1048576;
  localparam logic [SPEED_W-1:0] SPEED_FLOOR = 32'd367001600;
  localparam logic [SPEED_W-1:0] SPEED_CAP   = 32'd2621440000;
  localparam logic [SPEED_W-1:0] DECAY_MUL   = 32'd1073634450;
  localparam logic [SPEED_W-1:0] DECAY_SUB   = 32'd10486;

  localparam logic CH_LEFT  = 1'b0;
  localparam logic CH_RIGHT = 1'b1;

  typedef struct packed {
    logic                    en;
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [NUM_W-1:0]   num;
    logic [SPEED_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/core/spgc_if.sv
// Valid/ready stream interfaces for sample words in and out.
// Standalone; no package dependency.
interface spgc_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_left;
  logic signed [SAMPLE_BITS-1:0] sample_right;

  modport source (output valid, output sample_left, output sample_right, input ready);
  modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface spgc_out_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;

  modport source (output valid, output out_left, output out_right, input ready);
  modport sink (input valid, input out_left, input out_right, output ready);
endinterface

### rtl/core/spgc_mul.sv
// Shared signed multiplier with a registered product.
// Depends on spgc_pkg for operand widths and the request struct.
module spgc_mul (
  input  logic                              clk_i,
  input  spgc_pkg::mul_req_t                req_i,
  output logic signed [spgc_pkg::PROD_W-1:0] prod_o
);

  logic signed [spgc_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/core/spgc_div.sv
// Restoring divider, one quotient bit per cycle, for the gain chase.
// Depends on spgc_pkg for widths and the request/response structs.
module spgc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  spgc_pkg::div_req_t req_i,
  output spgc_pkg::div_rsp_t rsp_o
);

  logic [spgc_pkg::SPEED_W-1:0]   rem_q;
  logic [spgc_pkg::SPEED_W-1:0]   den_q;
  logic [spgc_pkg::QUOT_W-1:0]    quo_q;
  logic [spgc_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [spgc_pkg::SPEED_W:0]     trial;
  logic [spgc_pkg::SPEED_W:0]     diff;
  logic [spgc_pkg::SPEED_W:0]     rem_nx;
  logic                           fit;

  always_comb begin
    trial  = {rem_q, quo_q[spgc_pkg::QUOT_W-1]};
    fit    = trial >= {1'b0, den_q};
    diff   = trial - {1'b0, den_q};
    rem_nx = fit ? diff : trial;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (req_i.start) begin
      cnt_q  <= spgc_pkg::DIV_CNT_W'(spgc_pkg::QUOT_W);
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == spgc_pkg::DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num[spgc_pkg::NUM_W-1:spgc_pkg::QUOT_W];
      quo_q <= req_i.num[spgc_pkg::QUOT_W-1:0];
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= rem_nx[spgc_pkg::SPEED_W-1:0];
      quo_q <= {quo_q[spgc_pkg::QUOT_W-2:0], fit};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

### rtl/core/stereo_pan_gain_chaser.sv
// Stereo panner with chased per-channel gains; top level with sequencer.
// Depends on spgc_pkg, spgc_if, spgc_mul and spgc_div.
//
// Usage:
//   in_i carries one stereo frame word (sample_left, sample_right); out_o
//   returns one panned word per frame. Software sets the left and right
//   target gains (Q2.22) over the APB port at byte addresses 0 and 4;
//   reads return the stored targets. pready is always high.
//   Each frame runs the speed update and gain chase for the left channel,
//   then the right, on one shared multiplier and one 24-step divider,
//   then scales both samples on the same multiplier.
//   in_i.ready is high only while the sequencer is idle, so a new frame is
//   taken only after the last one has left the sequencer. The divider
//   runs 24 steps per channel and takes most of each frame's processing.
//   A finished word sits in the output register; while the receiver
//   stalls, the next frame is still accepted and processed, and its result
//   waits in the sequencer until the output register frees up.
//   Reset: targets return to unity, chased gains to zero, speeds to the
//   350.0 floor; the first frame after reset jumps the gains to target.
module stereo_pan_gain_chaser #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  spgc_in_if.sink                             in_i,
  spgc_out_if.source                          out_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [spgc_pkg::ADDR_W-1:0]         paddr,
  input  logic [spgc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [spgc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_PREP   = 4'd1;
  localparam logic [3:0] ST_DMUL   = 4'd2;
  localparam logic [3:0] ST_DEC    = 4'd3;
  localparam logic [3:0] ST_GMUL   = 4'd4;
  localparam logic [3:0] ST_DSTART = 4'd5;
  localparam logic [3:0] ST_DWAIT  = 4'd6;
  localparam logic [3:0] ST_OMUL_L = 4'd7;
  localparam logic [3:0] ST_OMUL_R = 4'd8;
  localparam logic [3:0] ST_OUT    = 4'd9;

  localparam int PW = spgc_pkg::PROD_W;
  localparam logic signed [PW-1:0] SAT_HI =
    {{(PW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [PW-1:0] SAT_LO =
    {{(PW-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [PW-1:0] TRUNC_ADJ =
    {{(PW-spgc_pkg::GAIN_FRAC){1'b0}}, {spgc_pkg::GAIN_FRAC{1'b1}}};

  logic [3:0]                       state_q;
  logic                             ch_q;
  logic                             started_q;
  logic [spgc_pkg::GAIN_W-1:0]      tgt_q   [2];
  logic [spgc_pkg::GAIN_W-1:0]      seen_q  [2];
  logic [spgc_pkg::GAIN_W-1:0]      gain_q  [2];
  logic [spgc_pkg::SPEED_W-1:0]     speed_q [2];
  logic [SAMPLE_BITS-1:0]           smp_l_q;
  logic [SAMPLE_BITS-1:0]           smp_r_q;
  logic [SAMPLE_BITS-1:0]           res_l_q;
  logic [SAMPLE_BITS-1:0]           out_l_q;
  logic [SAMPLE_BITS-1:0]           out_r_q;
  logic                             out_valid_q;

  logic [spgc_pkg::GAIN_W-1:0]      cur_tgt;
  logic [spgc_pkg::GAIN_W-1:0]      cur_gain;
  logic [spgc_pkg::SPEED_W-1:0]     cur_speed;
  logic [spgc_pkg::SPEED_W:0]       sp_dbl;
  logic [spgc_pkg::SPEED_W-1:0]     sp_cap;
  logic [spgc_pkg::SPEED_W-1:0]     dec_raw;
  logic [spgc_pkg::SPEED_W-1:0]     dec_flr;
  logic signed [PW-1:0]             prod;
  logic signed [PW-1:0]             prod_adj;
  logic signed [PW-1:0]             prod_shr;
  logic [SAMPLE_BITS-1:0]           sat_val;
  logic                             out_free;
  logic                             cfg_wr;

  spgc_pkg::mul_req_t mul_req;
  spgc_pkg::div_req_t div_req;
  spgc_pkg::div_rsp_t div_rsp;

  spgc_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  spgc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = {{(spgc_pkg::APB_DATA_W-spgc_pkg::GAIN_W){1'b0}},
                   tgt_q[paddr[spgc_pkg::ADDR_W-1]]};

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.out_left  = out_l_q;
  assign out_o.out_right = out_r_q;
  assign out_free        = !out_valid_q || out_o.ready;

  always_comb begin
    cur_tgt   = tgt_q[ch_q];
    cur_gain  = gain_q[ch_q];
    cur_speed = speed_q[ch_q];
    sp_dbl    = (cur_tgt != seen_q[ch_q]) ? {cur_speed, 1'b0} : {1'b0, cur_speed};
    sp_cap    = (sp_dbl > {1'b0, spgc_pkg::SPEED_CAP}) ? spgc_pkg::SPEED_CAP
                                                        : sp_dbl[spgc_pkg::SPEED_W-1:0];
    dec_raw   = prod[spgc_pkg::DECAY_SHIFT +: spgc_pkg::SPEED_W] - spgc_pkg::DECAY_SUB;
    dec_flr   = (dec_raw < spgc_pkg::SPEED_FLOOR) ? spgc_pkg::SPEED_FLOOR : dec_raw;
  end

  // truncate toward zero, then clamp to the sample range
  always_comb begin
    prod_adj = prod[PW-1] ? (prod + TRUNC_ADJ) : prod;
    prod_shr = prod_adj >>> spgc_pkg::GAIN_FRAC;
    if (prod_shr > SAT_HI) begin
      sat_val = SAT_HI[SAMPLE_BITS-1:0];
    end else if (prod_shr < SAT_LO) begin
      sat_val = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_val = prod_shr[SAMPLE_BITS-1:0];
    end
  end

  always_comb begin
    mul_req = '0;
    unique case (state_q)
      ST_DMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {1'b0, cur_speed};
        mul_req.b  = {1'b0, spgc_pkg::DECAY_MUL};
      end
      ST_GMUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(spgc_pkg::MUL_W-spgc_pkg::GAIN_W){1'b0}}, cur_gain};
        mul_req.b  = {1'b0, cur_speed};
      end
      ST_OMUL_L: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(spgc_pkg::MUL_W-SAMPLE_BITS){smp_l_q[SAMPLE_BITS-1]}}, smp_l_q};
        mul_req.b  = {{(spgc_pkg::MUL_W-spgc_pkg::GAIN_W){1'b0}}, gain_q[spgc_pkg::CH_LEFT]};
      end
      ST_OMUL_R: begin
        mul_req.en = 1'b1;
        mul_req.a  = {{(spgc_pkg::MUL_W-SAMPLE_BITS){smp_r_q[SAMPLE_BITS-1]}}, smp_r_q};
        mul_req.b  = {{(spgc_pkg::MUL_W-spgc_pkg::GAIN_W){1'b0}}, gain_q[spgc_pkg::CH_RIGHT]};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  always_comb begin
    div_req.start = (state_q == ST_DSTART);
    div_req.num   = prod[spgc_pkg::NUM_W-1:0]
                  + {{(spgc_pkg::NUM_W-spgc_pkg::GAIN_W-spgc_pkg::SPEED_FRAC){1'b0}},
                     cur_tgt, {spgc_pkg::SPEED_FRAC{1'b0}}};
    div_req.den   = cur_speed + spgc_pkg::SPEED_ONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= spgc_pkg::CH_LEFT;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        tgt_q[i]   <= spgc_pkg::GAIN_RESET;
        seen_q[i]  <= '0;
        gain_q[i]  <= '0;
        speed_q[i] <= spgc_pkg::SPEED_FLOOR;
      end
    end else begin
      if (cfg_wr) begin
        tgt_q[paddr[spgc_pkg::ADDR_W-1]] <= pwdata[spgc_pkg::GAIN_W-1:0];
      end
      if (out_valid_q && out_o.ready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            ch_q    <= spgc_pkg::CH_LEFT;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          speed_q[ch_q] <= sp_cap;
          seen_q[ch_q]  <= cur_tgt;
          if (!started_q) begin
            gain_q[ch_q] <= cur_tgt;
          end
          state_q <= ST_DMUL;
        end
        ST_DMUL: begin
          state_q <= ST_DEC;
        end
        ST_DEC: begin
          speed_q[ch_q] <= dec_flr;
          state_q       <= ST_GMUL;
        end
        ST_GMUL: begin
          state_q <= ST_DSTART;
        end
        ST_DSTART: begin
          state_q <= ST_DWAIT;
        end
        ST_DWAIT: begin
          if (div_rsp.done) begin
            gain_q[ch_q] <= div_rsp.quot;
            if (ch_q == spgc_pkg::CH_RIGHT) begin
              started_q <= 1'b1;
              ch_q      <= spgc_pkg::CH_LEFT;
              state_q   <= ST_OMUL_L;
            end else begin
              ch_q    <= spgc_pkg::CH_RIGHT;
              state_q <= ST_PREP;
            end
          end
        end
        ST_OMUL_L: begin
          state_q <= ST_OMUL_R;
        end
        ST_OMUL_R: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_i.valid) begin
      smp_l_q <= in_i.sample_left;
      smp_r_q <= in_i.sample_right;
    end
    if (state_q == ST_OMUL_R) begin
      res_l_q <= sat_val;
    end
    if (state_q == ST_OUT && out_free) begin
      out_l_q <= res_l_q;
      out_r_q <= sat_val;
    end
  end

endmodule

### rtl/core/spgc_checker.sv
// Port-level checks for the stereo pan gain chaser, bound to the top level.
// Depends only on the top level's ports.
module spgc_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_left_i,
  input logic [SAMPLE_BITS-1:0] out_right_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_left_i) && $stable(out_right_i))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready right after an accepted word");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after accept");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("output valid during reset");

endmodule

bind stereo_pan_gain_chaser spgc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_spgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_left_i  (out_o.out_left),
  .out_right_i (out_o.out_right)
);

### tb/tb_stereo_pan_gain_chaser.sv
`timescale 1ns / 1ps
// Self-checking bench for the stereo pan gain chaser: stereo frame words are
// predicted from APB targets or given by table rows; compared word by word.
// Depends on spgc_pkg, spgc_if and the stereo_pan_gain_chaser top level.
module tb_stereo_pan_gain_chaser;

  localparam int SB            = 24;
  localparam int RANDOM_FRAMES = 835;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 128;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct packed {
    sample_t left;
    sample_t right;
  } frame_t;

  typedef enum logic {REG_TGT_LEFT, REG_TGT_RIGHT} reg_idx_e;
  typedef enum logic {ROW_WRITE, ROW_FRAME} row_kind_e;
  typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_e;

  typedef struct packed {
    row_kind_e                   kind;
    reg_idx_e                    idx;
    logic [spgc_pkg::GAIN_W-1:0] value;
    sample_t                     left;
    sample_t                     right;
    logic                        has_exp;
    sample_t                     exp_left;
    sample_t                     exp_right;
  } stim_row_t;

  localparam sample_t S_MAX  = 24'sh7FFFFF;
  localparam sample_t S_MIN  = 24'sh800000;
  localparam sample_t S_ZERO = 24'sh000000;
  localparam sample_t S_ONE  = 24'sh000001;
  localparam sample_t S_NEG1 = 24'shFFFFFF;
  localparam sample_t S_ALT  = 24'shAAAAAB;

  localparam logic [spgc_pkg::GAIN_W-1:0] GAIN_ZERO = 24'd0;
  localparam logic [spgc_pkg::GAIN_W-1:0] GAIN_TWO  = 24'd8388608;
  localparam logic [spgc_pkg::GAIN_W-1:0] GAIN_TOP  = 24'hFFFFFF;
  localparam logic [spgc_pkg::GAIN_W-1:0] GAIN_UNIT = spgc_pkg::GAIN_RESET;

  localparam int N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_WRITE, REG_TGT_LEFT, GAIN_ZERO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MAX, S_MIN, 1'b1, S_ZERO, S_MIN},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MIN, S_MAX, 1'b1, S_ZERO, S_MAX},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_NEG1, S_ONE, 1'b1, S_ZERO, S_ONE},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, 24'sh2AAAAA, S_ALT, 1'b1, S_ZERO, S_ALT},
    '{ROW_WRITE, REG_TGT_RIGHT, GAIN_TWO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MAX, S_MAX, 1'b1, S_ZERO, S_MAX},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MIN, S_MIN, 1'b1, S_ZERO, S_MIN},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_ZERO, S_ZERO, 1'b1, S_ZERO, S_ZERO},
    '{ROW_WRITE, REG_TGT_RIGHT, GAIN_TOP, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MAX, S_MAX, 1'b1, S_ZERO, S_MAX},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, 24'sh400000, 24'shC00000, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MIN, 24'sh123456, 1'b0, S_ZERO, S_ZERO},
    '{ROW_WRITE, REG_TGT_LEFT, GAIN_TWO, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MAX, S_MIN, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, 24'sd123, -24'sd456, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MIN, S_ONE, 1'b0, S_ZERO, S_ZERO},
    '{ROW_WRITE, REG_TGT_LEFT, GAIN_UNIT, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO},
    '{ROW_WRITE, REG_TGT_RIGHT, GAIN_UNIT, S_ZERO, S_ZERO, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MAX, S_MAX, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, S_MIN, S_MIN, 1'b0, S_ZERO, S_ZERO},
    '{ROW_FRAME, REG_TGT_LEFT, GAIN_ZERO, 24'sh5A5A5A, 24'shA5A5A5, 1'b0, S_ZERO, S_ZERO}
  };

  logic                              clk_i;
  logic                              rst_ni;
  logic                              psel;
  logic                              penable;
  logic                              pwrite;
  logic [spgc_pkg::ADDR_W-1:0]       paddr;
  logic [spgc_pkg::APB_DATA_W-1:0]   pwdata;
  logic [spgc_pkg::APB_DATA_W-1:0]   prdata;
  logic                              pready;

  spgc_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  spgc_out_if #(.SAMPLE_BITS(SB)) out_if ();

  stereo_pan_gain_chaser #(.SAMPLE_BITS(SB)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // chase state of the panner
  logic [spgc_pkg::GAIN_W-1:0]  target_reg [2];
  logic [spgc_pkg::GAIN_W-1:0]  gain_chased [2];
  logic [spgc_pkg::SPEED_W-1:0] chase_speed [2];
  logic [spgc_pkg::GAIN_W-1:0]  last_target [2];
  bit                           chase_running;

  frame_t      expected_words [$];
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned holds_asked;
  int unsigned error_count;
  int unsigned words_checked;
  int unsigned frames_sent;
  int unsigned writes_done;

  task automatic log_mismatch(input string what);
    error_count++;
    $display("ERROR at %0t: %s", $time, what);
  endtask

  function automatic void chase_gain(input logic ch);
    logic [63:0]                 sp;
    logic [63:0]                 g;
    logic [spgc_pkg::GAIN_W-1:0] tgt;
    tgt = target_reg[ch];
    sp  = 64'(chase_speed[ch]);
    if (tgt != last_target[ch]) begin
      sp = sp << 1;
      last_target[ch] = tgt;
    end
    if (sp > 64'(spgc_pkg::SPEED_CAP)) sp = 64'(spgc_pkg::SPEED_CAP);
    if (!chase_running) gain_chased[ch] = tgt;
    sp = ((sp * 64'(spgc_pkg::DECAY_MUL)) >> spgc_pkg::DECAY_SHIFT)
         - 64'(spgc_pkg::DECAY_SUB);
    if (sp < 64'(spgc_pkg::SPEED_FLOOR)) sp = 64'(spgc_pkg::SPEED_FLOOR);
    chase_speed[ch] = sp[spgc_pkg::SPEED_W-1:0];
    g = (64'(gain_chased[ch]) * sp + (64'(tgt) << spgc_pkg::SPEED_FRAC))
        / (sp + 64'(spgc_pkg::SPEED_ONE));
    gain_chased[ch] = g[spgc_pkg::GAIN_W-1:0];
  endfunction

  function automatic sample_t scale_sample(input sample_t s,
                                           input logic [spgc_pkg::GAIN_W-1:0] g);
    longint p;
    longint q;
    p = longint'(s) * longint'({40'b0, g});
    if (p < 0) q = -((-p) >>> spgc_pkg::GAIN_FRAC);
    else q = p >>> spgc_pkg::GAIN_FRAC;
    if (q > longint'(S_MAX)) q = longint'(S_MAX);
    if (q < longint'(S_MIN)) q = longint'(S_MIN);
    return q[SB-1:0];
  endfunction

  function automatic frame_t pan_frame(input sample_t left, input sample_t right);
    frame_t res;
    chase_gain(spgc_pkg::CH_LEFT);
    chase_gain(spgc_pkg::CH_RIGHT);
    chase_running = 1'b1;
    res.left  = scale_sample(left, gain_chased[spgc_pkg::CH_LEFT]);
    res.right = scale_sample(right, gain_chased[spgc_pkg::CH_RIGHT]);
    return res;
  endfunction

  function automatic logic [spgc_pkg::GAIN_W-1:0] pick_target(
    input logic [spgc_pkg::GAIN_W-1:0] now);
    case ($urandom_range(9, 0))
      0: return GAIN_ZERO;
      1: return GAIN_UNIT;
      2: return GAIN_TWO;
      3: return GAIN_TOP;
      4: return now;
      default: return spgc_pkg::GAIN_W'($urandom_range(GAIN_TWO, 0));
    endcase
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(7, 0))
      0: return S_MAX;
      1: return S_MIN;
      2: return sample_t'(int'($urandom_range(512, 0)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic write_target(input reg_idx_e idx,
                              input logic [spgc_pkg::GAIN_W-1:0] value);
    logic [spgc_pkg::APB_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= spgc_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= {(spgc_pkg::APB_DATA_W-spgc_pkg::GAIN_W)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    target_reg[idx] = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[spgc_pkg::GAIN_W-1:0] !== value)
      log_mismatch($sformatf("readback of %s: got %0d, want %0d",
                             idx.name(), rd[spgc_pkg::GAIN_W-1:0], value));
    writes_done++;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input sample_t left, input sample_t right,
                            input bit use_exp, input frame_t exp_word);
    frame_t want;
    while ($urandom_range(99, 0) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.sample_left  <= left;
    in_if.sample_right <= right;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    want = pan_frame(left, right);
    expected_words.push_back(use_exp ? exp_word : want);
    frames_sent++;
  endtask

  // drop valid and wait for every outstanding word
  task automatic hold_input();
    in_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_word(input sample_t got_l, input sample_t got_r);
    frame_t want;
    if (expected_words.size() == 0) begin
      log_mismatch($sformatf("word L=%0d R=%0d with nothing outstanding", got_l, got_r));
      return;
    end
    want = expected_words.pop_front();
    words_checked++;
    if (got_l !== want.left)
      log_mismatch($sformatf("word %0d out_left: got %0d, want %0d",
                             words_checked, got_l, want.left));
    if (got_r !== want.right)
      log_mismatch($sformatf("word %0d out_right: got %0d, want %0d",
                             words_checked, got_r, want.right));
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) check_word(out_if.out_left, out_if.out_right);
      if (holds_asked != holds_served) begin
        hold_left = LONG_HOLD;
        holds_served++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= rst_ni && ($urandom_range(99, 0) >= sink_idle_pct);
      end
    end
  end

  initial begin
    stim_row_t   row;
    pace_e       pace;
    int unsigned seg_len;
    int unsigned random_sent;
    bit          hold_armed;

    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.sample_left  <= '0;
    in_if.sample_right <= '0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    holds_asked   = 0;
    error_count   = 0;
    words_checked = 0;
    frames_sent   = 0;
    writes_done   = 0;
    target_reg[spgc_pkg::CH_LEFT]   = GAIN_UNIT;
    target_reg[spgc_pkg::CH_RIGHT]  = GAIN_UNIT;
    gain_chased[spgc_pkg::CH_LEFT]  = '0;
    gain_chased[spgc_pkg::CH_RIGHT] = '0;
    chase_speed[spgc_pkg::CH_LEFT]  = spgc_pkg::SPEED_FLOOR;
    chase_speed[spgc_pkg::CH_RIGHT] = spgc_pkg::SPEED_FLOOR;
    last_target[spgc_pkg::CH_LEFT]  = '0;
    last_target[spgc_pkg::CH_RIGHT] = '0;
    chase_running = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_WRITE) begin
        hold_input();
        write_target(row.idx, row.value);
      end else begin
        send_frame(row.left, row.right, row.has_exp, {row.exp_left, row.exp_right});
      end
    end

    random_sent = 0;
    hold_armed  = 1'b1;
    while (random_sent < RANDOM_FRAMES) begin
      pace = pace_e'((random_sent * 3) / RANDOM_FRAMES);
      case (pace)
        PACE_SLOW_SINK: begin
          src_idle_pct  = 16;
          sink_idle_pct = 80;
        end
        PACE_SLOW_SOURCE: begin
          src_idle_pct  = 80;
          sink_idle_pct = 16;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      hold_input();
      if ($urandom_range(3, 0) != 0)
        write_target(REG_TGT_LEFT, pick_target(target_reg[REG_TGT_LEFT]));
      if ($urandom_range(3, 0) != 0)
        write_target(REG_TGT_RIGHT, pick_target(target_reg[REG_TGT_RIGHT]));
      // short bursts stack target changes so the speed reaches its cap
      seg_len = ($urandom_range(99, 0) < 60) ? $urandom_range(8, 2) : $urandom_range(120, 30);
      if (pace == PACE_FULL && hold_armed) begin
        hold_armed = 1'b0;
        holds_asked++;
        seg_len = 80;
      end
      if (seg_len > RANDOM_FRAMES - random_sent) seg_len = RANDOM_FRAMES - random_sent;
      repeat (seg_len) begin
        send_frame(random_sample(), random_sample(), 1'b0, '0);
        random_sent++;
      end
    end

    hold_input();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d frames (%0d directed table rows) and %0d target writes with readback,",
             frames_sent, N_DIRECTED, writes_done);
    $display("across slow-sink, slow-source and full-rate pacing; %0d words compared.",
             words_checked);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
